// File: src/ptsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the pinned-handle table.
// No dependencies; the top level and the sequencer import this package.
package ptsr_pkg;

	// field widths fixed by the interface
	localparam int MODE_W   = 2;
	localparam int HANDLE_W = 64;
	localparam int SLOT_W   = 11;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 12;
	localparam int ENTRY_W  = 64;

	// parameter defaults
	localparam int CAPACITY_DEF     = 2048;
	localparam int HANDLE_WIDTH_DEF = 64;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_PIN   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UNPIN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0]   slot;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic [ENTRY_W-1:0]  entry;
	} rsp_t;

endpackage

// File: src/pin_table_swap_remove.sv
`timescale 1ns / 1ps
// Pinned-handle table with swap-remove: top level, response register.
// Depends on ptsr_pkg, ptsr_mem, ptsr_ctrl.
//
//  port group   dir  payload          transfer
//  in_*         in   ptsr_pkg::req_t  in_valid & in_ready
//  out_*        out  ptsr_pkg::rsp_t  out_valid & out_ready
//
// Pin and clear finish in decode, read goes through S_RD, and unpin scans
// from the first entry to a match or to the fill count: the scan reads one
// entry per cycle from the single-port-read store; the last entry fills the hit slot.
// Reset clears the fill count and state only; the store needs no sweep.
// A new request is taken while the previous response waits in the output
// register; the sequencer holds its next response until that register frees.
module pin_table_swap_remove #(
	parameter int CAPACITY     = ptsr_pkg::CAPACITY_DEF,
	parameter int HANDLE_WIDTH = ptsr_pkg::HANDLE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ptsr_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ptsr_pkg::rsp_t out_data
);
	import ptsr_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FW = $clog2(CAPACITY + 1);

	logic                    res_valid;
	logic                    res_take;
	rsp_t                    res;
	logic                    mem_we;
	logic [AW-1:0]           mem_wr_addr;
	logic [HANDLE_WIDTH-1:0] mem_wr_data;
	logic [AW-1:0]           mem_rd_addr;
	logic [HANDLE_WIDTH-1:0] mem_rd_data;

	logic out_valid_q;
	rsp_t out_q;

	assign res_take = res_valid && (!out_valid_q || out_ready);

	ptsr_ctrl #(
		.CAPACITY    (CAPACITY),
		.HANDLE_WIDTH(HANDLE_WIDTH),
		.AW          (AW),
		.FW          (FW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req        (in_data),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.mem_we     (mem_we),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	ptsr_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(HANDLE_WIDTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/ptsr_mem.sv
`timescale 1ns / 1ps
// Entry store: one write port, one read port, registered read data.
// Depends on nothing; sized by the top level.
module ptsr_mem #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 64,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/ptsr_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: decodes a request, drives the entry store, keeps the fill count
// and builds the response. Depends on ptsr_pkg.
module ptsr_ctrl #(
	parameter int CAPACITY     = 2048,
	parameter int HANDLE_WIDTH = 64,
	parameter int AW           = 11,
	parameter int FW           = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ptsr_pkg::req_t          req,
	output logic                    res_valid,
	input  logic                    res_take,
	output ptsr_pkg::rsp_t          res,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_wr_addr,
	output logic [HANDLE_WIDTH-1:0] mem_wr_data,
	output logic [AW-1:0]           mem_rd_addr,
	input  logic [HANDLE_WIDTH-1:0] mem_rd_data
);
	import ptsr_pkg::*;

	localparam int CMPW = (FW > SLOT_W) ? FW : SLOT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_RD,
		S_RESP
	} state_t;

	state_t                  state_q;
	logic [FW-1:0]           fill_q;
	logic [FW-1:0]           idx_q;
	logic [HANDLE_WIDTH-1:0] h_q;
	logic [STATUS_W-1:0]     status_q;
	logic [ENTRY_W-1:0]      entry_q;

	logic [HANDLE_WIDTH-1:0] h;
	logic                    h_zero;
	logic                    full;
	logic                    slot_ok;
	logic [CMPW-1:0]         slot_ext;
	logic [FW-1:0]           idx_nxt;
	logic [FW-1:0]           fill_dec;
	logic                    hit;

	assign h        = req.handle[HANDLE_WIDTH-1:0];
	assign h_zero   = (h == '0);
	assign full     = (fill_q == FW'(CAPACITY));
	assign slot_ext = CMPW'(req.slot);
	assign slot_ok  = (slot_ext < CMPW'(fill_q));
	assign idx_nxt  = idx_q + FW'(1);
	assign fill_dec = fill_q - FW'(1);
	assign hit      = (mem_rd_data == h_q);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = '{status: status_q, count: COUNT_W'(fill_q), entry: entry_q};

	// store port control
	always_comb begin
		mem_we      = 1'b0;
		mem_wr_addr = fill_q[AW-1:0];
		mem_wr_data = h;
		mem_rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_we = in_valid && (req.mode == MODE_PIN) && !h_zero && !full;
				if (req.mode == MODE_READ) begin
					mem_rd_addr = slot_ext[AW-1:0];
				end
			end
			S_SCAN: begin
				// on a hit fetch the last entry, else keep streaming
				mem_rd_addr = hit ? fill_dec[AW-1:0] : idx_nxt[AW-1:0];
			end
			S_LAST: begin
				mem_we      = 1'b1;
				mem_wr_addr = idx_q[AW-1:0];
				mem_wr_data = mem_rd_data;
			end
			S_RD, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			idx_q    <= '0;
			h_q      <= '0;
			status_q <= ST_DONE;
			entry_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						entry_q  <= '0;
						status_q <= ST_DONE;
						state_q  <= S_RESP;
						unique case (req.mode)
							MODE_PIN: begin
								if (h_zero) begin
									status_q <= ST_ZERO;
								end else if (full) begin
									status_q <= ST_FULL;
								end else begin
									fill_q <= fill_q + FW'(1);
								end
							end
							MODE_UNPIN: begin
								h_q   <= h;
								idx_q <= '0;
								if (h_zero) begin
									status_q <= ST_ZERO;
								end else if (fill_q == '0) begin
									status_q <= ST_MISSING;
								end else begin
									state_q <= S_SCAN;
								end
							end
							MODE_CLEAR: begin
								fill_q <= '0;
							end
							MODE_READ: begin
								if (slot_ok) begin
									state_q <= S_RD;
								end else begin
									status_q <= ST_RANGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					// read data belongs to idx_q
					if (hit) begin
						state_q <= S_LAST;
					end else if (idx_nxt == fill_q) begin
						status_q <= ST_MISSING;
						state_q  <= S_RESP;
					end else begin
						idx_q <= idx_nxt;
					end
				end
				S_LAST: begin
					fill_q  <= fill_dec;
					state_q <= S_RESP;
				end
				S_RD: begin
					entry_q <= ENTRY_W'(mem_rd_data);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CAPACITY))
		else $error("fill count beyond capacity");

	a_fill_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_LAST))
		else $error("fill count changed outside decode or swap");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_LAST) |-> (idx_q < fill_q))
		else $error("scan index beyond fill count");

	a_entry_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && entry_q != '0) |-> (status_q == ST_DONE))
		else $error("entry returned with failing status");

	a_write_when: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_LAST || (state_q == S_IDLE && !full)))
		else $error("store written at wrong time");

endmodule
